@@ rtl/dit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dit_pkg;

  // Longest token, sign included, that may still give a value.
  localparam int MAX_TOKEN_CHARS = 11;

  // Character counter width; the counter saturates at its all-ones value.
  localparam int CNT_W = 4;

  // Depths of the token queue (front to back) and of the result queue.
  localparam int TOK_DEPTH = 4;
  localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  // Magnitude limits for the two signs, and the saturation value above them.
  localparam logic [31:0] MAG_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] MAG_NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] MAG_CLAMP   = 32'h8000_0001;

  // Byte codes of interest.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Byte classes produced by the front part.
  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_PLUS  = 3'd2,
    CLS_MINUS = 3'd3,
    CLS_OTHER = 3'd4
  } cls_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_RANGE = 2'd2,
    ST_END   = 2'd3
  } status_t;

  // One classified byte.
  typedef struct packed {
    cls_t       cls;
    logic [3:0] dval;
    logic       fin;
  } tok_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/dit_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dit_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_char_byte,
  input  wire logic           in_is_final,
  input  wire logic           in_push,
  output logic                in_full,
  output logic                tok_valid,
  output dit_pkg::tok_t       tok,
  input  wire logic           tok_pop
);

  dit_pkg::tok_t                   mem_r [dit_pkg::TOK_DEPTH];
  logic [dit_pkg::TOK_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dit_pkg::TOK_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dit_pkg::TOK_PTR_W:0]     cnt_r, cnt_nxt;
  dit_pkg::tok_t                   cls_tok;
  logic                            wr_en;
  logic                            rd_en;

  // Classify the incoming byte.
  always_comb begin
    cls_tok.fin  = in_is_final;
    cls_tok.dval = 4'(in_char_byte - dit_pkg::CH_ZERO);
    if ((in_char_byte >= dit_pkg::CH_TAB && in_char_byte <= dit_pkg::CH_CR) ||
        in_char_byte == dit_pkg::CH_SPACE) begin
      cls_tok.cls = dit_pkg::CLS_SPACE;
    end else if (in_char_byte >= dit_pkg::CH_ZERO && in_char_byte <= dit_pkg::CH_NINE) begin
      cls_tok.cls = dit_pkg::CLS_DIGIT;
    end else if (in_char_byte == dit_pkg::CH_PLUS) begin
      cls_tok.cls = dit_pkg::CLS_PLUS;
    end else if (in_char_byte == dit_pkg::CH_MINUS) begin
      cls_tok.cls = dit_pkg::CLS_MINUS;
    end else begin
      cls_tok.cls = dit_pkg::CLS_OTHER;
    end
  end

  // Queue control.
  assign in_full   = (cnt_r == (dit_pkg::TOK_PTR_W+1)'(dit_pkg::TOK_DEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = mem_r[rd_ptr_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = tok_pop && tok_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls_tok;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dit_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dit_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tok_valid,
  input  wire dit_pkg::tok_t  tok,
  output logic                tok_pop,
  output logic                res_empty,
  output dit_pkg::res_t       res,
  input  wire logic           res_pop
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SIGN    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [31:0]                   acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic [dit_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [31:0]                   acc_base;
  logic [dit_pkg::CNT_W-1:0]     cnt_base;
  logic [35:0]                   acc_x10;
  logic [31:0]                   acc_dig;
  logic [dit_pkg::CNT_W-1:0]     cnt_inc;
  logic                          is_digit;

  logic [31:0]                   f_acc;
  logic [dit_pkg::CNT_W-1:0]     f_cnt;
  logic                          f_neg;
  logic [31:0]                   f_lim;
  logic                          f_range;
  logic [31:0]                   f_value;

  logic                          do_finish;
  logic                          do_fail;
  logic                          emit;
  dit_pkg::status_t              emit_status;
  dit_pkg::res_t                 emit_res;

  dit_pkg::res_t                 rq_r [dit_pkg::RES_DEPTH];
  logic [dit_pkg::RES_PTR_W-1:0] rq_wr_r, rq_wr_nxt;
  logic [dit_pkg::RES_PTR_W-1:0] rq_rd_r, rq_rd_nxt;
  logic [dit_pkg::RES_PTR_W:0]   rq_cnt_r, rq_cnt_nxt;
  logic                          rq_full;
  logic                          rq_push;
  logic                          rq_rd_en;

  // A byte is taken whenever the result queue has room for what it may produce.
  assign rq_full = (rq_cnt_r == (dit_pkg::RES_PTR_W+1)'(dit_pkg::RES_DEPTH));
  assign tok_pop = tok_valid && !rq_full;
  assign is_digit = (tok.cls == dit_pkg::CLS_DIGIT);

  // Multiply-by-ten accumulate; a new token starts from zero.
  always_comb begin
    acc_base = (phase_r == PH_IDLE) ? 32'd0 : acc_r;
    cnt_base = (phase_r == PH_IDLE) ? '0 : cnt_r;
    acc_x10  = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) + {32'd0, tok.dval};
    acc_dig  = (acc_x10 > {4'd0, dit_pkg::MAG_NEG_MAX}) ? dit_pkg::MAG_CLAMP
                                                        : acc_x10[31:0];
    cnt_inc  = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
  end

  // Token close: range check and signed value.
  always_comb begin
    f_acc   = is_digit ? acc_dig : acc_r;
    f_cnt   = is_digit ? cnt_inc : cnt_r;
    f_neg   = (phase_r == PH_IDLE) ? 1'b0 : neg_r;
    f_lim   = f_neg ? dit_pkg::MAG_NEG_MAX : dit_pkg::MAG_POS_MAX;
    f_range = (f_cnt > dit_pkg::CNT_W'(dit_pkg::MAX_TOKEN_CHARS)) || (f_acc > f_lim);
    f_value = f_neg ? (32'd0 - f_acc) : f_acc;
  end

  // Token state machine.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    cnt_nxt     = cnt_r;
    do_finish   = 1'b0;
    do_fail     = 1'b0;
    emit        = 1'b0;
    emit_status = dit_pkg::ST_BAD;
    emit_res    = '0;

    if (tok_pop) begin
      case (phase_r)
        PH_DISCARD: begin
          if (tok.fin) begin
            phase_nxt = PH_IDLE;
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            cnt_nxt   = '0;
          end
        end
        PH_IDLE: begin
          case (tok.cls)
            dit_pkg::CLS_SPACE: begin
              if (tok.fin) begin
                emit        = 1'b1;
                emit_status = dit_pkg::ST_END;
              end
            end
            dit_pkg::CLS_PLUS, dit_pkg::CLS_MINUS: begin
              if (tok.fin) begin
                do_fail = 1'b1;
              end else begin
                phase_nxt = PH_SIGN;
                acc_nxt   = '0;
                neg_nxt   = (tok.cls == dit_pkg::CLS_MINUS);
                cnt_nxt   = dit_pkg::CNT_W'(1);
              end
            end
            dit_pkg::CLS_DIGIT: begin
              if (tok.fin) begin
                do_finish = 1'b1;
              end else begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = acc_dig;
                neg_nxt   = 1'b0;
                cnt_nxt   = cnt_inc;
              end
            end
            default: begin
              do_fail = 1'b1;
            end
          endcase
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            if (tok.fin) begin
              do_finish = 1'b1;
            end else begin
              phase_nxt = PH_DIGITS;
              acc_nxt   = acc_dig;
              cnt_nxt   = cnt_inc;
            end
          end else if (phase_r == PH_DIGITS && tok.cls == dit_pkg::CLS_SPACE) begin
            do_finish = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // A finished token either gives its value or fails as out of range; a malformed one fails as bad.
      if (do_finish && !f_range) begin
        phase_nxt      = PH_IDLE;
        acc_nxt        = '0;
        neg_nxt        = 1'b0;
        cnt_nxt        = '0;
        emit           = 1'b1;
        emit_res.value = f_value;
        emit_res.last  = tok.fin;
        emit_status    = dit_pkg::ST_OK;
      end else if (do_finish || do_fail) begin
        phase_nxt   = tok.fin ? PH_IDLE : PH_DISCARD;
        acc_nxt     = '0;
        neg_nxt     = 1'b0;
        cnt_nxt     = '0;
        emit        = 1'b1;
        emit_status = do_finish ? dit_pkg::ST_RANGE : dit_pkg::ST_BAD;
      end

      if (emit && emit_status != dit_pkg::ST_OK) begin
        emit_res.value = '0;
        emit_res.last  = 1'b1;
      end
    end
    emit_res.status = emit_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result queue control.
  assign rq_push   = emit;
  assign res_empty = (rq_cnt_r == '0);
  assign res       = rq_r[rq_rd_r];
  assign rq_rd_en  = res_pop && !res_empty;

  always_comb begin
    rq_wr_nxt  = rq_push ? rq_wr_r + 1'b1 : rq_wr_r;
    rq_rd_nxt  = rq_rd_en ? rq_rd_r + 1'b1 : rq_rd_r;
    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_rd_en) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (!rq_push && rq_rd_en) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      rq_wr_r  <= rq_wr_nxt;
      rq_rd_r  <= rq_rd_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= emit_res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/decimal_integer_tokenizer.sv @@
// Decimal integer tokenizer: takes a string one byte per transaction and gives one
// result per token (signed 32-bit value, status, end-of-string flag). A front part
// classifies each byte into a four-entry queue; a back part runs the token state
// machine with a combinational multiply-by-ten accumulate and writes results into a
// two-entry queue. One byte is taken every cycle when the result side keeps up; with
// both queues empty, the byte that ends a token is registered in the token queue and
// its result is then registered in the result queue, on the output ports to be popped.
// The sustained rate is set by the back part's one-byte-per-cycle accumulate loop.
`timescale 1ns / 1ps
`default_nettype none

module decimal_integer_tokenizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_char_byte,
  input  wire logic               in_is_final,
  input  wire logic               push,
  output logic                    full,
  output logic signed [31:0]      out_value,
  output logic [1:0]              out_status,
  output logic                    out_last_of_string,
  output logic                    empty,
  input  wire logic               pop
);

  logic          tok_valid;
  logic          tok_pop;
  dit_pkg::tok_t tok;
  dit_pkg::res_t res;

  // Front part: classify and queue bytes.
  dit_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_byte (in_char_byte),
    .in_is_final  (in_is_final),
    .in_push      (push),
    .in_full      (full),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop)
  );

  // Back part: token state machine and result queue.
  dit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_empty (empty),
    .res       (res),
    .res_pop   (pop)
  );

  assign out_value          = $signed(res.value);
  assign out_status         = res.status;
  assign out_last_of_string = res.last;

  // An error or end-only result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != dit_pkg::ST_OK) |-> (out_value == 32'sd0))
    else $error("non-ok result with nonzero value");

  // An error or end-only result always closes the string.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != dit_pkg::ST_OK) |-> out_last_of_string)
    else $error("non-ok result without last_of_string");

  // The back part never takes a byte while no byte is queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |-> tok_valid)
    else $error("token popped from empty queue");

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (empty && !full && !tok_valid))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire
